/* rtl/asq_pkg.sv */
package asq_pkg;

    // Configuration register indexes
    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_QUANT_BITS   = 3'd0;
    localparam t_cfg_idx CFG_STEP_GAIN    = 3'd1;
    localparam t_cfg_idx CFG_LEAK_FACTOR  = 3'd2;
    localparam t_cfg_idx CFG_ALPHA_WEIGHT = 3'd3;
    localparam t_cfg_idx CFG_MIN_POWER    = 3'd4;
    localparam t_cfg_idx CFG_CODE_MAX     = 3'd5;
    localparam t_cfg_idx CFG_CODE_MIN     = 3'd6;

    // Register reset values
    localparam logic [3:0]         QUANT_BITS_RST   = 4'd5;
    localparam logic [15:0]        STEP_GAIN_RST    = 16'd256;
    localparam logic [5:0]         LEAK_FACTOR_RST  = 6'd28;
    localparam logic [10:0]        ALPHA_WEIGHT_RST = 11'd1000;
    localparam logic [14:0]        MIN_POWER_RST    = 15'd10;
    localparam logic [6:0]         CODE_MAX_RST     = 7'd15;
    localparam logic signed [7:0]  CODE_MIN_RST     = -8'sd16;

    // Arithmetic constants
    localparam logic [10:0] ALPHA_ONE  = 11'd1024;   // unity smoothing weight
    localparam logic [5:0]  LEAK_ONE   = 6'd32;      // unity leak
    localparam int          POW_FRAC   = 10;         // power weight fraction bits
    localparam int          PRED_FRAC  = 5;          // leak fraction bits
    localparam logic [4:0]  STEP_SH_OFS = 5'd4;      // step shift = quant_bits + 4
    localparam int          SAT_LIMIT  = 32767;      // end-of-segment saturation
    localparam int          STEP_RST   = 1 << (16 - 5);
    localparam int          POWER_RST  = 10;

endpackage

/* rtl/asq_mul.sv */
// Shared signed multiplier, product registered.
module asq_mul #(
    parameter int A_W = 34,
    parameter int B_W = 17
) (
    input  logic                     i_clk,
    input  logic signed [A_W-1:0]    i_a,
    input  logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0] o_p
);

    logic signed [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

/* rtl/adaptive_subband_quantizer_core.sv */
// Flow: a new sample is taken only after the previous code has been handed
//   to the output register; s_tready is high only while idle. Each item
//   goes through a restoring divider (overflow check plus 9 quotient bits)
//   and five passes through one shared multiplier.
// Reset: i_rst_n synchronous, active low; registers take their reset values,
//   prediction 0, step size 2048, power 10. No clearing pass.
module adaptive_subband_quantizer_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // [SAMPLE_WIDTH-1:0] sample
    input  logic                  s_tlast,   // last_of_segment
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] code
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    // ------------------------------------------------------------------
    // Widths. Power never exceeds max(2^(SW-1), 32767); step follows from
    // gain (16 bits) times power shifted down by at least 4.
    // ------------------------------------------------------------------
    localparam int SW    = SAMPLE_WIDTH;
    localparam int PWR_W = (SW > 16) ? SW : 16;
    localparam int ST_W  = PWR_W + 12;
    localparam int NUM_W = ((ST_W > 33) ? ST_W : 33) + 1;   // |diff| + half step
    localparam int DW    = NUM_W + 9;                         // shifted divisor
    localparam int MA_W  = ((ST_W + 1 > 33) ? ST_W + 1 : 33) + 1;
    localparam int MB_W  = 17;
    localparam int P_W   = MA_W + MB_W;
    localparam int ACC_W = PWR_W + 11;
    localparam int GP_W  = PWR_W + 16;

    localparam logic signed [P_W-1:0] EST_HI = P_W'((64'sd1 <<< (SW-1)) - 64'sd1);
    localparam logic signed [P_W-1:0] EST_LO = P_W'(-(64'sd1 <<< (SW-1)));
    localparam logic signed [P_W-1:0] I32_HI = P_W'(64'sd2147483647);
    localparam logic signed [P_W-1:0] I32_LO = P_W'(-64'sd2147483648);
    localparam logic signed [31:0]    SMP_HI = 32'((64'sd1 <<< (SW-1)) - 64'sd1);
    localparam logic signed [31:0]    SMP_LO = 32'(-(64'sd1 <<< (SW-1)));

    // ------------------------------------------------------------------
    // Sequencer states
    // ------------------------------------------------------------------
    localparam logic [3:0] S_IDLE = 4'd0;   // wait for a sample
    localparam logic [3:0] S_DIFF = 4'd1;   // residual, divider setup
    localparam logic [3:0] S_DIV  = 4'd2;   // restoring division, overflow check then quotient bits
    localparam logic [3:0] S_CODE = 4'd3;   // sign and clip the quotient
    localparam logic [3:0] S_EST  = 4'd4;   // mul: code * step
    localparam logic [3:0] S_EST2 = 4'd5;   // clamp reconstructed difference
    localparam logic [3:0] S_P1   = 4'd6;   // mul: alpha * power
    localparam logic [3:0] S_P2   = 4'd7;   // mul: (1024 - alpha) * |est|
    localparam logic [3:0] S_P3   = 4'd8;   // accumulate
    localparam logic [3:0] S_PW   = 4'd9;   // round, floor at min_power
    localparam logic [3:0] S_ST   = 4'd10;  // mul: gain * power
    localparam logic [3:0] S_STR  = 4'd11;  // new step; mul: (pred + est) * leak
    localparam logic [3:0] S_PRED = 4'd12;  // new prediction, segment end clamps
    localparam logic [3:0] S_OUT  = 4'd13;  // hand the code to the output register

    logic [3:0] r_state;

    // configuration
    logic [3:0]         r_qbits;
    logic [15:0]        r_gain;
    logic [5:0]         r_leak;
    logic [10:0]        r_alpha;
    logic [14:0]        r_minp;
    logic [6:0]         r_cmax;
    logic signed [7:0]  r_cmin;

    // channel state
    logic signed [31:0] r_pred;
    logic [ST_W-1:0]    r_step;
    logic [PWR_W-1:0]   r_pwr;

    // per-item working registers
    logic [SW-1:0]        r_smp;
    logic                 r_last;
    logic                 r_neg;
    logic [NUM_W-1:0]     r_rem;
    logic [DW-1:0]        r_dvs;
    logic [8:0]           r_q;
    logic                 r_ovf;
    logic [3:0]           r_cnt;
    logic signed [7:0]    r_code;
    logic signed [SW-1:0] r_est;
    logic [SW-1:0]        r_mag;
    logic signed [32:0]   r_sum;
    logic [ACC_W-1:0]     r_acc;

    // output register
    logic                 r_mvalid;
    logic [7:0]           r_mdata;

    // shared multiplier
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [P_W-1:0]  mul_p;

    asq_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [10:0]        alpha_c;
    logic [5:0]         leak_c;
    logic signed [32:0] diff;
    logic [32:0]        diff_abs;
    logic [NUM_W-1:0]   num;
    logic               div_ge;
    logic [8:0]         qv;
    logic signed [9:0]  code_full;
    logic signed [9:0]  cmax_x;
    logic signed [9:0]  cmin_x;
    logic signed [7:0]  code_clip;
    logic signed [SW-1:0] est;
    logic [ACC_W-1:0]   pw_rnd;
    logic [PWR_W-1:0]   pw;
    logic [4:0]         st_sh;
    logic [GP_W:0]      st_sum;
    logic [GP_W:0]      st_full;
    logic [ST_W-1:0]    st;
    logic signed [P_W-1:0] pr_full;
    logic signed [31:0] pr_new;
    logic signed [31:0] pr_seg;

    assign s_tready    = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_mvalid;
    assign m_tdata     = r_mdata;

    always_comb begin
        alpha_c = (r_alpha > asq_pkg::ALPHA_ONE) ? asq_pkg::ALPHA_ONE : r_alpha;
        leak_c  = (r_leak > asq_pkg::LEAK_ONE) ? asq_pkg::LEAK_ONE : r_leak;

        // residual magnitude plus half a step: rounding away from zero
        diff     = $signed({{(33-SW){r_smp[SW-1]}}, r_smp}) - $signed({r_pred[31], r_pred});
        diff_abs = diff[32] ? 33'(-diff) : 33'(diff);
        num      = {{(NUM_W-33){1'b0}}, diff_abs}
                 + {{(NUM_W-ST_W+1){1'b0}}, r_step[ST_W-1:1]};

        div_ge = ({9'd0, r_rem} >= r_dvs);

        // any quotient of 512 or more clips the same way as 511
        qv        = r_ovf ? 9'h1FF : r_q;
        code_full = r_neg ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
        cmax_x    = $signed({3'b000, r_cmax});
        cmin_x    = {{2{r_cmin[7]}}, r_cmin};
        priority if (code_full > cmax_x) begin
            code_clip = $signed({1'b0, r_cmax});
        end else if (code_full < cmin_x) begin
            code_clip = r_cmin;
        end else begin
            code_clip = code_full[7:0];
        end

        // reconstructed difference, clamped to the sample range
        priority if (mul_p > EST_HI) begin
            est = EST_HI[SW-1:0];
        end else if (mul_p < EST_LO) begin
            est = EST_LO[SW-1:0];
        end else begin
            est = mul_p[SW-1:0];
        end

        // power: round by 2^10, floor at min_power
        pw_rnd = r_acc + ACC_W'(1 << (asq_pkg::POW_FRAC - 1));
        pw     = pw_rnd[PWR_W+asq_pkg::POW_FRAC-1:asq_pkg::POW_FRAC];
        if (pw < {{(PWR_W-15){1'b0}}, r_minp}) begin
            pw = {{(PWR_W-15){1'b0}}, r_minp};
        end

        // step: round by 2^(quant_bits+4), floor at 1
        st_sh   = {1'b0, r_qbits} + asq_pkg::STEP_SH_OFS;
        st_sum  = {1'b0, mul_p[GP_W-1:0]} + ((GP_W+1)'(1) << (st_sh - 5'd1));
        st_full = st_sum >> st_sh;
        st      = st_full[ST_W-1:0];
        if (st == '0) begin
            st = ST_W'(1);
        end

        // prediction: round to nearest by 2^5, ties toward plus infinity, saturate to 32 bits
        pr_full = (mul_p + P_W'(1 << (asq_pkg::PRED_FRAC - 1))) >>> asq_pkg::PRED_FRAC;
        priority if (pr_full > I32_HI) begin
            pr_new = I32_HI[31:0];
        end else if (pr_full < I32_LO) begin
            pr_new = I32_LO[31:0];
        end else begin
            pr_new = pr_full[31:0];
        end
        priority if (pr_new > SMP_HI) begin
            pr_seg = SMP_HI;
        end else if (pr_new < SMP_LO) begin
            pr_seg = SMP_LO;
        end else begin
            pr_seg = pr_new;
        end

        // multiplier operand select
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_EST: begin
                mul_a = $signed({{(MA_W-ST_W){1'b0}}, r_step});
                mul_b = {{(MB_W-8){r_code[7]}}, r_code};
            end
            S_P1: begin
                mul_a = $signed({{(MA_W-PWR_W){1'b0}}, r_pwr});
                mul_b = $signed({{(MB_W-11){1'b0}}, alpha_c});
            end
            S_P2: begin
                mul_a = $signed({{(MA_W-SW){1'b0}}, r_mag});
                mul_b = $signed({{(MB_W-11){1'b0}}, 11'(asq_pkg::ALPHA_ONE - alpha_c)});
            end
            S_ST: begin
                mul_a = $signed({{(MA_W-PWR_W){1'b0}}, r_pwr});
                mul_b = $signed({1'b0, r_gain});
            end
            S_STR: begin
                mul_a = {{(MA_W-33){r_sum[32]}}, r_sum};
                mul_b = $signed({{(MB_W-6){1'b0}}, leak_c});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qbits <= asq_pkg::QUANT_BITS_RST;
            r_gain  <= asq_pkg::STEP_GAIN_RST;
            r_leak  <= asq_pkg::LEAK_FACTOR_RST;
            r_alpha <= asq_pkg::ALPHA_WEIGHT_RST;
            r_minp  <= asq_pkg::MIN_POWER_RST;
            r_cmax  <= asq_pkg::CODE_MAX_RST;
            r_cmin  <= asq_pkg::CODE_MIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                asq_pkg::CFG_QUANT_BITS:   r_qbits <= i_cfg_data[3:0];
                asq_pkg::CFG_STEP_GAIN:    r_gain  <= i_cfg_data;
                asq_pkg::CFG_LEAK_FACTOR:  r_leak  <= i_cfg_data[5:0];
                asq_pkg::CFG_ALPHA_WEIGHT: r_alpha <= i_cfg_data[10:0];
                asq_pkg::CFG_MIN_POWER:    r_minp  <= i_cfg_data[14:0];
                asq_pkg::CFG_CODE_MAX:     r_cmax  <= i_cfg_data[6:0];
                asq_pkg::CFG_CODE_MIN:     r_cmin  <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and channel state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pred   <= '0;
            r_step   <= ST_W'(asq_pkg::STEP_RST);
            r_pwr    <= PWR_W'(asq_pkg::POWER_RST);
            r_mvalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            // S_OUT reloads the output register itself
            if (r_mvalid && m_tready && (r_state != S_OUT)) begin
                r_mvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_smp   <= s_tdata[SW-1:0];
                        r_last  <= s_tlast;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_neg   <= diff[32];
                    r_rem   <= num;
                    r_dvs   <= {{(DW-ST_W-9){1'b0}}, r_step, 9'd0};
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // first pass checks for a quotient of 512 or more
                    if (r_cnt == 4'd0) begin
                        r_ovf <= div_ge;
                    end else begin
                        if (div_ge) begin
                            r_rem <= r_rem - r_dvs[NUM_W-1:0];
                        end
                        r_q <= {r_q[7:0], div_ge};
                    end
                    r_dvs <= r_dvs >> 1;
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd9) begin
                        r_state <= S_CODE;
                    end
                end
                S_CODE: begin
                    r_code  <= code_clip;
                    r_state <= S_EST;
                end
                S_EST: begin
                    r_state <= S_EST2;
                end
                S_EST2: begin
                    r_est   <= est;
                    r_mag   <= est[SW-1] ? SW'(-est) : SW'(est);
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_sum   <= $signed({r_pred[31], r_pred})
                             + $signed({{(33-SW){r_est[SW-1]}}, r_est});
                    r_state <= S_P2;
                end
                S_P2: begin
                    r_acc   <= mul_p[ACC_W-1:0];
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_acc   <= r_acc + mul_p[ACC_W-1:0];
                    r_state <= S_PW;
                end
                S_PW: begin
                    r_pwr   <= pw;
                    r_state <= S_ST;
                end
                S_ST: begin
                    r_state <= S_STR;
                end
                S_STR: begin
                    r_step  <= st;
                    r_state <= S_PRED;
                end
                S_PRED: begin
                    // segment end: prediction to sample range, step and power saturate
                    if (r_last) begin
                        r_pred <= pr_seg;
                        if (r_step > ST_W'(asq_pkg::SAT_LIMIT)) begin
                            r_step <= ST_W'(asq_pkg::SAT_LIMIT);
                        end
                        if (r_pwr > PWR_W'(asq_pkg::SAT_LIMIT)) begin
                            r_pwr <= PWR_W'(asq_pkg::SAT_LIMIT);
                        end
                    end else begin
                        r_pred <= pr_new;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_mvalid || m_tready) begin
                        r_mvalid <= 1'b1;
                        r_mdata  <= r_code;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
